// ----- rtl/ffba_pkg.sv -----
// shared types and constants of the first-fit block allocator
package ffba_pkg;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [1:0] REG_HEAP_BASE  = 2'd0;
    localparam logic [1:0] REG_HEAP_LIMIT = 2'd1;

    localparam logic [31:0] HEAP_LIMIT_RESET = 32'd4063232;
    localparam logic [31:0] TRAIL_BYTES      = 32'd4;

    typedef struct packed {
        logic        op;
        logic [23:0] request_size;
        logic [31:0] release_address;
    } t_cmd;

    typedef struct packed {
        logic [31:0] block_address;
        logic [1:0]  status;
        logic [31:0] bytes_used;
    } t_result;

    // scan token handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic        found;
        logic [31:0] off;
        logic [23:0] len;
    } t_tok;

endpackage

// ----- rtl/ffba_cell.sv -----
// one block entry of the chain: holds length and busy mark, updates the passing token
module ffba_cell #(
    parameter int IDX          = 0,
    parameter int TW           = 7,
    parameter int HEADER_BYTES = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffba_pkg::t_cmd  i_cmd,
    input  logic [31:0]     i_base,
    input  logic [TW-1:0]   i_total,
    input  logic            i_wr_en,
    input  logic [TW-1:0]   i_wr_idx,
    input  ffba_pkg::t_tok  i_tok,
    output ffba_pkg::t_tok  o_tok
);

    logic [23:0]    r_len;
    logic           r_busy;
    ffba_pkg::t_tok r_tok;
    ffba_pkg::t_tok n_tok;
    logic           in_use;
    logic           match;
    logic           hit;
    logic [31:0]    hdr;

    assign hdr    = 32'(HEADER_BYTES);
    assign in_use = i_total > TW'(IDX);

    // fit test for allocate, address compare for release
    always_comb begin
        if (i_cmd.op == ffba_pkg::OP_ALLOC) begin
            match = !r_busy && (r_len >= i_cmd.request_size);
        end else begin
            match = (i_base + i_tok.off + hdr) == i_cmd.release_address;
        end
        hit = i_tok.valid && !i_tok.found && in_use && match;
    end

    // next token
    always_comb begin
        n_tok       = i_tok;
        n_tok.found = i_tok.found || hit;
        if (hit) begin
            n_tok.len = r_len;
        end
        if (!hit && !i_tok.found && in_use) begin
            n_tok.off = i_tok.off + {8'd0, r_len} + hdr + ffba_pkg::TRAIL_BYTES;
        end
    end

    // token register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found <= n_tok.found;
        r_tok.off   <= n_tok.off;
        r_tok.len   <= n_tok.len;
    end

    // entry contents
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_idx == TW'(IDX)) begin
            r_len  <= i_cmd.request_size;
            r_busy <= 1'b1;
        end else if (hit) begin
            r_busy <= (i_cmd.op == ffba_pkg::OP_ALLOC);
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- rtl/first_fit_block_allocator_top.sv -----
// top level of the first-fit block allocator: command control and cell chain
//
// Usage:
// - command channel: present i_cmd with start high while busy is low; the
//   command is taken at that edge. op 0 allocates request_size bytes, op 1
//   releases the block at release_address.
// - result channel: o_res_valid is high for exactly one cycle with o_result;
//   the receiver must take it then, it cannot stall the block.
// - config channel: i_cfg_valid with i_cfg_index/i_cfg_data, o_cfg_ready is
//   always high; index 0 heap_base, index 1 heap_limit. Write only when idle.
// - command flow: a zero-size allocate answers in the cycle after acceptance.
//   Every other command sends a token down the chain of MAX_BLOCKS cells,
//   one cell per cycle, through the injection register, the cell token
//   registers and the result register; busy stays high until the result
//   is out, so no new command is taken while a scan runs.
// - reset: block count, heap end and byte count clear, heap_base to 0,
//   heap_limit to 4063232; cell contents are only read below the count.
module first_fit_block_allocator_top #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ffba_pkg::t_cmd    i_cmd,
    output logic              o_res_valid,
    output ffba_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam int TW = $clog2(MAX_BLOCKS + 1);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic              r_state;
    logic [31:0]       r_base;
    logic [31:0]       r_limit;
    logic [TW-1:0]     r_total;
    logic [31:0]       r_end;
    logic [31:0]       r_used;
    logic [33:0]       r_new_end;
    ffba_pkg::t_cmd    r_cmd;
    logic              r_res_valid;
    ffba_pkg::t_result r_result;
    logic              r_inject;

    ffba_pkg::t_tok    tok [MAX_BLOCKS+1];
    ffba_pkg::t_tok    tail;
    logic              accept;
    logic              zero_req;
    logic              wr_en;
    logic [31:0]       hdr;
    logic [34:0]       end_addr;

    assign hdr         = 32'(HEADER_BYTES);
    assign accept      = start && !busy;
    assign zero_req    = (i_cmd.op == ffba_pkg::OP_ALLOC) && (i_cmd.request_size == 24'd0);
    assign busy        = (r_state == S_SCAN);
    assign o_cfg_ready = 1'b1;
    assign tail        = tok[MAX_BLOCKS];
    assign end_addr    = {3'd0, r_base} + {1'b0, r_new_end};

    // injected token
    always_comb begin
        tok[0].valid = r_inject;
        tok[0].found = 1'b0;
        tok[0].off   = 32'd0;
        tok[0].len   = 24'd0;
    end

    // chain of block cells
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell #(
            .IDX          (g),
            .TW           (TW),
            .HEADER_BYTES (HEADER_BYTES)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (r_cmd),
            .i_base   (r_base),
            .i_total  (r_total),
            .i_wr_en  (wr_en),
            .i_wr_idx (r_total),
            .i_tok    (tok[g]),
            .o_tok    (tok[g+1])
        );
    end

    // append into the next free cell
    assign wr_en = tail.valid && !tail.found && (r_cmd.op == ffba_pkg::OP_ALLOC)
                   && (r_total != TW'(MAX_BLOCKS))
                   && (end_addr <= {3'd0, r_limit});

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 32'd0;
            r_limit <= ffba_pkg::HEAP_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == ffba_pkg::REG_HEAP_BASE) begin
                r_base <= i_cfg_data;
            end else if (i_cfg_index == ffba_pkg::REG_HEAP_LIMIT) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_cmd;
            r_new_end <= {2'd0, r_end} + {10'd0, i_cmd.request_size}
                         + {2'd0, hdr} + {2'd0, ffba_pkg::TRAIL_BYTES};
        end
    end

    // control and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_end       <= 32'd0;
            r_used      <= 32'd0;
            r_res_valid <= 1'b0;
            r_inject    <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            r_inject    <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (zero_req) begin
                            r_res_valid              <= 1'b1;
                            r_result.block_address   <= 32'd0;
                            r_result.status          <= ffba_pkg::ST_ZERO;
                            r_result.bytes_used      <= r_used;
                        end else begin
                            r_inject <= 1'b1;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (tail.valid) begin
                        r_state                <= S_IDLE;
                        r_res_valid            <= 1'b1;
                        r_result.block_address <= 32'd0;
                        r_result.bytes_used    <= r_used;
                        if (r_cmd.op == ffba_pkg::OP_ALLOC) begin
                            if (tail.found) begin
                                r_result.block_address <= r_base + tail.off + hdr;
                                r_result.status        <= ffba_pkg::ST_OK;
                                r_result.bytes_used    <= r_used
                                    + {8'd0, r_cmd.request_size} + hdr;
                                r_used <= r_used + {8'd0, r_cmd.request_size} + hdr;
                            end else if (wr_en) begin
                                r_result.block_address <= r_base + r_end + hdr;
                                r_result.status        <= ffba_pkg::ST_OK;
                                r_result.bytes_used    <= r_used
                                    + {8'd0, r_cmd.request_size} + hdr
                                    + ffba_pkg::TRAIL_BYTES;
                                r_used <= r_used + {8'd0, r_cmd.request_size} + hdr
                                    + ffba_pkg::TRAIL_BYTES;
                                r_total <= r_total + TW'(1);
                                r_end   <= r_new_end[31:0];
                            end else begin
                                r_result.status <= ffba_pkg::ST_NOSPACE;
                            end
                        end else begin
                            if (tail.found) begin
                                r_result.status     <= ffba_pkg::ST_OK;
                                r_result.bytes_used <= r_used - {8'd0, tail.len} - hdr;
                                r_used <= r_used - {8'd0, tail.len} - hdr;
                            end else begin
                                r_result.status <= ffba_pkg::ST_UNKNOWN;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

`ifndef SYNTHESIS
    // a non-trivial command starts a scan
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !zero_req |=> busy)
        else $error("scan did not start");

    // the token only leaves the chain during a scan
    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.valid |-> r_state == S_SCAN)
        else $error("token outside scan");

    // the block count never passes the table size
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(MAX_BLOCKS))
        else $error("block count overflow");

    // a scan ends with a result
    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && tail.valid |=> o_res_valid && !busy)
        else $error("scan ended without result");
`endif

endmodule
